>>> sv/nlp_pkg.sv
package nlp_pkg;

  // bits per nibble and per count field (counts reach at most 9)
  localparam int NIB_W = 4;
  localparam int CNT_W = 4;
  // a 32-bit word holds at most eight nibbles
  localparam int MAX_WORD_NIBBLES = 8;

  localparam logic [NIB_W-1:0] PAD_NIB   = 4'hF;
  localparam logic [7:0]       TERM_BYTE = 8'hFF;

  // number of nibble positions of the word that can be nonzero
  function automatic int sig_positions(input int word_nibbles);
    sig_positions = (word_nibbles > MAX_WORD_NIBBLES) ? MAX_WORD_NIBBLES : word_nibbles;
  endfunction

endpackage

>>> sv/nlp_if.sv
interface nlp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word_in;
  logic        stream_end;

  modport source (output valid, output word_in, output stream_end, input ready);
  modport sink   (input valid, input word_in, input stream_end, output ready);
endinterface

interface nlp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       final_byte;

  modport source (output valid, output out_byte, output run_end, output final_byte,
                  input ready);
  modport sink   (input valid, input out_byte, input run_end, input final_byte,
                  output ready);
endinterface

>>> sv/nibble_length_prefix_packer.sv
// channel  | dir | payload                           | handshake
// in_ch    | in  | word_in[31:0], stream_end         | valid / ready
// out_ch   | out | out_byte[7:0], run_end, final_byte| valid / ready
//
// a word leaves the queue, then the back-end sequencer emits one byte per
// cycle while the output is not stalled, plus a step that parks an odd
// nibble and, on the last word of a stream, a step for the close byte
// a two-entry queue lets the front accept words while the back end stalls
// rst is synchronous and clears the queue, the held nibble and the output
module nibble_length_prefix_packer
  import nlp_pkg::*;
#(
  parameter int WORD_NIBBLES = 8
) (
  input  logic      clk,
  input  logic      rst,
  nlp_in_if.sink    in_ch,
  nlp_out_if.source out_ch
);

  localparam int NV = NIB_W * (sig_positions(WORD_NIBBLES) + 1);
  localparam int EW = NV + CNT_W + 1;

  logic [NV-1:0]    f_nibs;
  logic [CNT_W-1:0] f_rem;
  logic             f_last;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic [EW-1:0]    q_data;

  nlp_front #(.WORD_NIBBLES(WORD_NIBBLES)) u_front (
    .word_in    (in_ch.word_in),
    .stream_end (in_ch.stream_end),
    .nibs       (f_nibs),
    .rem        (f_rem),
    .last       (f_last)
  );

  assign in_ch.ready = !q_full;

  nlp_fifo #(.WIDTH(EW)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_ch.valid),
    .push_data ({f_nibs, f_rem, f_last}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  nlp_back #(.WORD_NIBBLES(WORD_NIBBLES)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_nibs  (q_data[EW-1 -: NV]),
    .q_rem   (q_data[CNT_W:1]),
    .q_last  (q_data[0]),
    .out_ch  (out_ch)
  );

endmodule

>>> sv/nlp_front.sv
module nlp_front
  import nlp_pkg::*;
#(
  parameter int WORD_NIBBLES = 8
) (
  input  logic [31:0]                                   word_in,
  input  logic                                          stream_end,
  output logic [NIB_W*(sig_positions(WORD_NIBBLES)+1)-1:0] nibs,
  output logic [CNT_W-1:0]                              rem,
  output logic                                          last
);

  localparam int SIG_N = sig_positions(WORD_NIBBLES);
  localparam int WW    = NIB_W * SIG_N;

  logic [WW-1:0]    masked;
  logic [CNT_W-1:0] sig;
  logic [CNT_W-1:0] lead_zero;
  logic [WW-1:0]    aligned;

  assign masked = word_in[WW-1:0];

  // highest nonzero nibble sets the count
  always_comb begin
    sig = '0;
    for (int k = 0; k < SIG_N; k++) begin
      if (masked[NIB_W*k +: NIB_W] != '0) begin
        sig = CNT_W'(k + 1);
      end
    end
  end

  // left-align the significant nibbles under the header
  assign lead_zero = CNT_W'(SIG_N) - sig;
  assign aligned   = masked << {lead_zero, 2'b00};

  assign nibs = {sig, aligned};
  assign rem  = sig + CNT_W'(1);
  assign last = stream_end;

endmodule

>>> sv/nlp_fifo.sv
module nlp_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wp;
  logic             rp;
  logic [1:0]       count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = mem[rp];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) wp <= ~wp;
      if (pop && !empty) rp <= ~rp;
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

>>> sv/nlp_back.sv
module nlp_back
  import nlp_pkg::*;
#(
  parameter int WORD_NIBBLES = 8
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          q_empty,
  output logic                                          q_pop,
  input  logic [NIB_W*(sig_positions(WORD_NIBBLES)+1)-1:0] q_nibs,
  input  logic [CNT_W-1:0]                              q_rem,
  input  logic                                          q_last,
  nlp_out_if.source                                     out_ch
);

  localparam int NV = NIB_W * (sig_positions(WORD_NIBBLES) + 1);

  logic             busy;
  logic [NV-1:0]    nibs;
  logic [CNT_W-1:0] rem;
  logic             last;
  logic             pend;
  logic [NIB_W-1:0] held;

  logic             out_valid;
  logic [7:0]       out_byte;
  logic             run_end;
  logic             final_byte;

  logic             slot_free;
  logic             step;
  logic             emit;
  logic [NIB_W-1:0] top_nib;
  logic [NIB_W-1:0] second_nib;

  assign slot_free  = !out_valid || out_ch.ready;
  assign step       = busy && slot_free;
  // every step loads a byte except the one that parks an odd nibble
  assign emit       = step && !(rem == CNT_W'(1) && !pend);
  assign q_pop      = !busy && !q_empty;
  assign top_nib    = nibs[NV-1 -: NIB_W];
  assign second_nib = nibs[NV-NIB_W-1 -: NIB_W];

  assign out_ch.valid      = out_valid;
  assign out_ch.out_byte   = out_byte;
  assign out_ch.run_end    = run_end;
  assign out_ch.final_byte = final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pend      <= 1'b0;
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        busy <= 1'b1;
        nibs <= q_nibs;
        rem  <= q_rem;
        last <= q_last;
      end else if (step) begin
        if (rem != '0) begin
          if (pend) begin
            // complete the held byte with one nibble
            out_byte   <= {held, top_nib};
            run_end    <= !last && (rem - CNT_W'(1) < CNT_W'(2));
            final_byte <= 1'b0;
            nibs       <= nibs << NIB_W;
            rem        <= rem - CNT_W'(1);
            pend       <= 1'b0;
            if (rem == CNT_W'(1) && !last) busy <= 1'b0;
          end else if (rem >= CNT_W'(2)) begin
            out_byte   <= {top_nib, second_nib};
            run_end    <= !last && (rem - CNT_W'(2) < CNT_W'(2));
            final_byte <= 1'b0;
            nibs       <= nibs << (2 * NIB_W);
            rem        <= rem - CNT_W'(2);
            if (rem == CNT_W'(2) && !last) busy <= 1'b0;
          end else begin
            // odd nibble left: hold it for the next word or the close byte
            held <= top_nib;
            pend <= 1'b1;
            rem  <= '0;
            if (!last) busy <= 1'b0;
          end
        end else begin
          // only reached on the last word of a stream
          out_byte   <= pend ? {held, PAD_NIB} : TERM_BYTE;
          run_end    <= 1'b1;
          final_byte <= 1'b1;
          pend       <= 1'b0;
          held       <= '0;
          busy       <= 1'b0;
        end
      end
    end
  end

endmodule

>>> sv/nlp_checker.sv
module nlp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_end,
  input logic       final_byte
);

  // stream close byte always ends its run
  assert property (@(posedge clk) disable iff (rst)
    out_valid && final_byte |-> run_end)
    else $error("final byte without run end");

  // close byte is either padded or the terminator, low half is all ones
  assert property (@(posedge clk) disable iff (rst)
    out_valid && final_byte |-> out_byte[3:0] == 4'hF)
    else $error("final byte low nibble not padded");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_end)
      && $stable(final_byte))
    else $error("stalled output transfer changed");

endmodule

bind nibble_length_prefix_packer nlp_checker u_nlp_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.out_byte),
  .run_end    (out_ch.run_end),
  .final_byte (out_ch.final_byte)
);
